// File: design/rsalu_pkg.sv
// Package for the reservation station ALU unit: request/result structs,
// action and opcode codes, controller state encoding. No dependencies.
package rsalu_pkg;

  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned TAG_COUNT_DEF = 32;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned TAG_W         = 5;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned ACT_W         = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT    = 3'd0,
    ACT_BROADCAST = 3'd1,
    ACT_TICK      = 3'd2,
    ACT_FIND      = 3'd3,
    ACT_RELEASE   = 3'd4,
    ACT_FLUSH     = 3'd5
  } action_t;

  typedef enum logic [OP_W-1:0] {
    OP_EQ  = 4'd0,  OP_NE  = 4'd1,  OP_LT  = 4'd2,  OP_GE  = 4'd3,
    OP_LTU = 4'd4,  OP_GEU = 4'd5,  OP_ADD = 4'd6,  OP_XOR = 4'd7,
    OP_OR  = 4'd8,  OP_AND = 4'd9,  OP_SLL = 4'd10, OP_SRL = 4'd11,
    OP_SRA = 4'd12, OP_SUB = 4'd13, OP_MUL = 4'd14, OP_DIV = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic              writes_reg;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic              a_pending;
    logic [TAG_W-1:0]  a_tag;
    logic              b_pending;
    logic [TAG_W-1:0]  b_tag;
    logic [OP_W-1:0]   opcode;
    logic [TAG_W-1:0]  entry_tag;
    logic [DATA_W-1:0] bus_value;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot_index;
    logic [TAG_W-1:0]  result_tag;
    logic [DATA_W-1:0] result_value;
    logic              result_writes_reg;
    logic              issued;
  } rsp_t;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_DONE = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;    // capture request
    logic exec;        // apply the captured action
    logic div_start;   // latch divider operands
    logic div_step;    // one quotient bit
    logic div_finish;  // commit divide result
    logic out_load;    // load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_div;      // captured tick selects a divide
    logic div_last;    // last divider step in progress
  } sts_t;

endpackage

// File: design/reservation_station_alu_unit.sv
// Reservation station with one ALU, sixteen slots by default: insert,
// broadcast, tick, find-done, release and flush, one request at a time.
// An accepted request goes through execute and then output load; the next
// request is accepted once the controller is idle again. A tick that issues a
// divide also runs 32 one-bit steps of the restoring divider and a sign fixup.
// The output register lets the next request be accepted while a result waits.
// Depends on rsalu_pkg, rsalu_ctrl and rsalu_dp.
module reservation_station_alu_unit #(
  parameter int unsigned ENTRIES   = rsalu_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_COUNT = rsalu_pkg::TAG_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rsalu_pkg::req_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsalu_pkg::rsp_t  out_data
);

  rsalu_pkg::cmd_t cmd;
  rsalu_pkg::sts_t sts;

  rsalu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rsalu_dp #(
    .ENTRIES   (ENTRIES),
    .TAG_COUNT (TAG_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_data),
    .out_rsp (out_data),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

// File: design/rsalu_ctrl.sv
// Controller FSM for the reservation station ALU unit.
// Depends on rsalu_pkg. Sequences request capture, execute, divide, output.
module rsalu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rsalu_pkg::cmd_t     cmd,
  input  rsalu_pkg::sts_t     sts
);

  rsalu_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Accept a request only when idle; output register parts the two sides
  assign in_stall  = (state_r != rsalu_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      rsalu_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = rsalu_pkg::ST_EXEC;
        end
      end
      rsalu_pkg::ST_EXEC: begin
        if (sts.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = rsalu_pkg::ST_DIV;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = rsalu_pkg::ST_OUT;
        end
      end
      rsalu_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = rsalu_pkg::ST_DONE;
      end
      rsalu_pkg::ST_DONE: begin
        cmd.div_finish = 1'b1;
        cmd.exec       = 1'b1;
        state_nxt      = rsalu_pkg::ST_OUT;
      end
      rsalu_pkg::ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rsalu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsalu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsalu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A result is loaded only from the output state
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state_r == rsalu_pkg::ST_OUT)
    else $error("out_load outside output state");
  // After loading a result, valid is raised
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result lost");
  // Divider steps run only in the divide state
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> state_r == rsalu_pkg::ST_DIV)
    else $error("stray divide step");

endmodule

// File: design/rsalu_dp.sv
// Datapath for the reservation station ALU unit: slot storage, wakeup,
// select, ALU, serial divider, result register. Depends on rsalu_pkg.
module rsalu_dp #(
  parameter int unsigned ENTRIES   = rsalu_pkg::ENTRIES_DEF,
  parameter int unsigned TAG_COUNT = rsalu_pkg::TAG_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rsalu_pkg::req_t  in_req,
  output rsalu_pkg::rsp_t  out_rsp,
  input  rsalu_pkg::cmd_t  cmd,
  output rsalu_pkg::sts_t  sts
);

  localparam int unsigned DW  = rsalu_pkg::DATA_W;
  localparam int unsigned TW  = rsalu_pkg::TAG_W;
  localparam int unsigned SW  = rsalu_pkg::SLOT_W;
  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(DW);

  // Slot storage
  logic [ENTRIES-1:0] busy_r, done_r, await_r, bwait_r, writes_r;
  logic [DW-1:0] aval_r [ENTRIES];
  logic [DW-1:0] bval_r [ENTRIES];
  logic [TW-1:0] asrc_r [ENTRIES];
  logic [TW-1:0] bsrc_r [ENTRIES];
  logic [TW-1:0] id_r   [ENTRIES];
  logic [rsalu_pkg::OP_W-1:0] op_r [ENTRIES];
  logic [DW-1:0] res_r  [ENTRIES];

  logic          byp_valid_r;
  logic [TW-1:0] byp_tag_r;
  logic [DW-1:0] byp_value_r;

  rsalu_pkg::req_t req_r;
  rsalu_pkg::rsp_t rsp_r, rsp_nxt, out_r;

  // Tag reduction table, built at elaboration
  function automatic logic [(2**TW)*TW-1:0] tmod_table();
    logic [(2**TW)*TW-1:0] tab;
    tab = '0;
    for (int i = 0; i < 2**TW; i++) tab[i*TW +: TW] = TW'(i % TAG_COUNT);
    return tab;
  endfunction

  localparam logic [(2**TW)*TW-1:0] TMOD_TAB = tmod_table();

  // Tags reduced modulo TAG_COUNT
  function automatic logic [TW-1:0] tmod(input logic [TW-1:0] t);
    tmod = TMOD_TAB[32'(t)*TW +: TW];
  endfunction

  // Priority: lowest free slot, lowest ready slot, first done at/after start
  logic          free_hit, rdy_hit, fnd_hit;
  logic [IW-1:0] free_idx, rdy_idx, fnd_idx;
  always_comb begin
    free_hit = 1'b0; rdy_hit = 1'b0; fnd_hit = 1'b0;
    free_idx = '0;   rdy_idx = '0;   fnd_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_hit = 1'b1; free_idx = IW'(i);
      end
      if (busy_r[i] && !done_r[i] && !await_r[i] && !bwait_r[i]) begin
        rdy_hit = 1'b1; rdy_idx = IW'(i);
      end
      if (busy_r[i] && done_r[i] && (32'(i) >= 32'(req_r.slot))) begin
        fnd_hit = 1'b1; fnd_idx = IW'(i);
      end
    end
  end

  // Operands of the selected ready entry
  logic [DW-1:0] xa, yb, alu_res;
  logic [CW-1:0] sh;
  assign xa = aval_r[rdy_idx];
  assign yb = bval_r[rdy_idx];
  assign sh = yb[CW-1:0];

  // Restoring divider, one quotient bit per cycle
  logic [DW-1:0] div_q_r, div_rem_r, div_d_r, div_q_nxt, div_rem_nxt, div_res;
  logic          div_neg_r, div_zero_r;
  logic [CW-1:0] div_cnt_r;
  logic [DW:0]   trial;
  logic [DW-1:0] ax, ay;
  assign ax    = xa[DW-1] ? (DW'(0) - xa) : xa;
  assign ay    = yb[DW-1] ? (DW'(0) - yb) : yb;
  assign trial = {div_rem_r, div_q_r[DW-1]} - {1'b0, div_d_r};
  // Signed quotient: divide by zero gives all ones, sign applied otherwise
  assign div_res = div_zero_r ? '1 : (div_neg_r ? (DW'(0) - div_q_r) : div_q_r);

  // ALU on the selected ready entry
  always_comb begin
    case (op_r[rdy_idx])
      rsalu_pkg::OP_EQ:  alu_res = DW'(xa == yb);
      rsalu_pkg::OP_NE:  alu_res = DW'(xa != yb);
      rsalu_pkg::OP_LT:  alu_res = DW'($signed(xa) < $signed(yb));
      rsalu_pkg::OP_GE:  alu_res = DW'($signed(xa) >= $signed(yb));
      rsalu_pkg::OP_LTU: alu_res = DW'(xa < yb);
      rsalu_pkg::OP_GEU: alu_res = DW'(xa >= yb);
      rsalu_pkg::OP_ADD: alu_res = xa + yb;
      rsalu_pkg::OP_XOR: alu_res = xa ^ yb;
      rsalu_pkg::OP_OR:  alu_res = xa | yb;
      rsalu_pkg::OP_AND: alu_res = xa & yb;
      rsalu_pkg::OP_SLL: alu_res = xa << sh;
      rsalu_pkg::OP_SRL: alu_res = xa >> sh;
      rsalu_pkg::OP_SRA: alu_res = DW'($signed(xa) >>> sh);
      rsalu_pkg::OP_SUB: alu_res = xa - yb;
      rsalu_pkg::OP_MUL: alu_res = xa * yb;
      default:           alu_res = div_res;
    endcase
  end

  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    if (cmd.div_start) begin
      div_q_nxt   = ax;
      div_rem_nxt = '0;
    end else if (cmd.div_step) begin
      if (!trial[DW]) begin
        div_rem_nxt = trial[DW-1:0];
        div_q_nxt   = {div_q_r[DW-2:0], 1'b1};
      end else begin
        div_rem_nxt = {div_rem_r[DW-2:0], div_q_r[DW-1]};
        div_q_nxt   = {div_q_r[DW-2:0], 1'b0};
      end
    end else if (cmd.div_finish) begin
      div_q_nxt = div_res;
    end
  end

  always_ff @(posedge clk) begin
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    if (cmd.div_start) begin
      div_d_r    <= ay;
      div_neg_r  <= xa[DW-1] ^ yb[DW-1];
      div_zero_r <= (yb == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)             div_cnt_r <= '0;
    else if (cmd.div_start) div_cnt_r <= '0;
    else if (cmd.div_step)  div_cnt_r <= div_cnt_r + 1'b1;
  end

  assign sts.is_div   = (req_r.action == rsalu_pkg::ACT_TICK) && rdy_hit &&
                        (op_r[rdy_idx] == rsalu_pkg::OP_DIV);
  assign sts.div_last = (div_cnt_r == CW'(DW - 1));

  // Action decode into state updates and the response
  logic          wake_en;
  logic [TW-1:0] wake_tag;
  logic [DW-1:0] wake_val;
  logic [TW-1:0] ins_atag, ins_btag;
  assign ins_atag = tmod(req_r.a_tag);
  assign ins_btag = tmod(req_r.b_tag);

  always_comb begin
    rsp_nxt  = '0;
    wake_en  = 1'b0;
    wake_tag = tmod(req_r.entry_tag);
    wake_val = req_r.bus_value;
    unique case (req_r.action)
      rsalu_pkg::ACT_INSERT: begin
        rsp_nxt.status     = !free_hit;
        rsp_nxt.slot_index = SW'(free_idx);
      end
      rsalu_pkg::ACT_BROADCAST: wake_en = 1'b1;
      rsalu_pkg::ACT_TICK: begin
        rsp_nxt.status = !rdy_hit;
        if (rdy_hit) begin
          rsp_nxt.slot_index        = SW'(rdy_idx);
          rsp_nxt.result_tag        = id_r[rdy_idx];
          rsp_nxt.result_value      = alu_res;
          rsp_nxt.result_writes_reg = writes_r[rdy_idx];
          rsp_nxt.issued            = 1'b1;
          wake_en                   = writes_r[rdy_idx];
          wake_tag                  = id_r[rdy_idx];
          wake_val                  = alu_res;
        end
      end
      rsalu_pkg::ACT_FIND: begin
        rsp_nxt.status = !fnd_hit;
        if (fnd_hit) begin
          rsp_nxt.slot_index   = SW'(fnd_idx);
          rsp_nxt.result_tag   = id_r[fnd_idx];
          rsp_nxt.result_value = res_r[fnd_idx];
        end
      end
      rsalu_pkg::ACT_RELEASE: rsp_nxt.slot_index = req_r.slot;
      default: ;
    endcase
  end

  // Control bits of the slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      done_r      <= '0;
      await_r     <= '0;
      bwait_r     <= '0;
      byp_valid_r <= 1'b0;
      byp_tag_r   <= '0;
      byp_value_r <= '0;
    end else if (cmd.exec) begin
      // tick clears the bypass unless its own result is broadcast
      if (req_r.action == rsalu_pkg::ACT_TICK && !wake_en) begin
        byp_valid_r <= 1'b0;
        byp_tag_r   <= '0;
        byp_value_r <= '0;
      end
      if (wake_en) begin
        byp_valid_r <= 1'b1;
        byp_tag_r   <= wake_tag;
        byp_value_r <= wake_val;
        for (int i = 0; i < ENTRIES; i++) begin
          if (await_r[i] && asrc_r[i] == wake_tag) await_r[i] <= 1'b0;
          if (bwait_r[i] && bsrc_r[i] == wake_tag) bwait_r[i] <= 1'b0;
        end
      end
      if (req_r.action == rsalu_pkg::ACT_INSERT && free_hit) begin
        busy_r[free_idx]  <= 1'b1;
        done_r[free_idx]  <= 1'b0;
        await_r[free_idx] <= req_r.a_pending &&
                             !(byp_valid_r && ins_atag == byp_tag_r);
        bwait_r[free_idx] <= req_r.b_pending &&
                             !(byp_valid_r && ins_btag == byp_tag_r);
      end
      if (req_r.action == rsalu_pkg::ACT_TICK && rdy_hit) done_r[rdy_idx] <= 1'b1;
      if (req_r.action == rsalu_pkg::ACT_RELEASE &&
          32'(req_r.slot) < ENTRIES) begin
        busy_r[IW'(req_r.slot)]  <= 1'b0;
        done_r[IW'(req_r.slot)]  <= 1'b0;
        await_r[IW'(req_r.slot)] <= 1'b0;
        bwait_r[IW'(req_r.slot)] <= 1'b0;
      end
      if (req_r.action == rsalu_pkg::ACT_FLUSH) begin
        busy_r  <= '0;
        done_r  <= '0;
        await_r <= '0;
        bwait_r <= '0;
      end
    end
  end

  // Payload of the slots
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wake_en) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (await_r[i] && asrc_r[i] == wake_tag) aval_r[i] <= wake_val;
          if (bwait_r[i] && bsrc_r[i] == wake_tag) bval_r[i] <= wake_val;
        end
      end
      if (req_r.action == rsalu_pkg::ACT_INSERT && free_hit) begin
        writes_r[free_idx] <= req_r.writes_reg;
        aval_r[free_idx]   <= (req_r.a_pending && byp_valid_r && ins_atag == byp_tag_r)
                              ? byp_value_r : req_r.operand_a;
        bval_r[free_idx]   <= (req_r.b_pending && byp_valid_r && ins_btag == byp_tag_r)
                              ? byp_value_r : req_r.operand_b;
        asrc_r[free_idx]   <= ins_atag;
        bsrc_r[free_idx]   <= ins_btag;
        op_r[free_idx]     <= req_r.opcode;
        id_r[free_idx]     <= tmod(req_r.entry_tag);
      end
      if (req_r.action == rsalu_pkg::ACT_TICK && rdy_hit) res_r[rdy_idx] <= alu_res;
    end
  end

  // Request capture and response staging
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_req;
    if (cmd.exec)     rsp_r <= rsp_nxt;
    if (cmd.out_load) out_r <= rsp_r;
  end

  assign out_rsp = out_r;

  // A slot that is done is busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & ~busy_r) == '0)
    else $error("done slot not busy");
  // Bypass valid follows a broadcast
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && wake_en) |=> byp_valid_r)
    else $error("bypass not recorded");
  // A started divide begins at step zero
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> div_cnt_r == '0)
    else $error("divider count not cleared");

endmodule

// File: verif/tb_reservation_station_alu_unit.sv
// Testbench for reservation_station_alu_unit: random and directed requests,
// a built-in predictor of the station and ALU, and a field-wise result check.
// Depends on rsalu_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_reservation_station_alu_unit;

  localparam int NSLOT = 16;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rsalu_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsalu_pkg::rsp_t out_data;

  reservation_station_alu_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Station model state
  typedef struct {
    bit busy, done, writes, a_wait, b_wait;
    bit [31:0] a_val, b_val, res;
    bit [4:0] a_src, b_src, id;
    bit [3:0] op;
  } slot_t;

  slot_t slots [NSLOT];
  bit byp_valid;
  bit [4:0] byp_tag;
  bit [31:0] byp_value;

  rsalu_pkg::req_t pending_reqs[$];
  rsalu_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  longint cycles = 0;

  function automatic bit [31:0] alu_calc(bit [3:0] op, bit [31:0] x, bit [31:0] y);
    bit [31:0] ax, ay, q;
    case (rsalu_pkg::opcode_t'(op))
      rsalu_pkg::OP_EQ:  return {31'd0, x == y};
      rsalu_pkg::OP_NE:  return {31'd0, x != y};
      rsalu_pkg::OP_LT:  return {31'd0, $signed(x) < $signed(y)};
      rsalu_pkg::OP_GE:  return {31'd0, $signed(x) >= $signed(y)};
      rsalu_pkg::OP_LTU: return {31'd0, x < y};
      rsalu_pkg::OP_GEU: return {31'd0, x >= y};
      rsalu_pkg::OP_ADD: return x + y;
      rsalu_pkg::OP_XOR: return x ^ y;
      rsalu_pkg::OP_OR:  return x | y;
      rsalu_pkg::OP_AND: return x & y;
      rsalu_pkg::OP_SLL: return x << y[4:0];
      rsalu_pkg::OP_SRL: return x >> y[4:0];
      rsalu_pkg::OP_SRA: return $unsigned($signed(x) >>> y[4:0]);
      rsalu_pkg::OP_SUB: return x - y;
      rsalu_pkg::OP_MUL: return x * y;
      default: begin
        // divide by zero gives all ones; overflow wraps to min int
        if (y == 0) return 32'hFFFF_FFFF;
        ax = x[31] ? -x : x;
        ay = y[31] ? -y : y;
        q = ax / ay;
        return (x[31] != y[31]) ? -q : q;
      end
    endcase
  endfunction

  function automatic void wake_tag(bit [4:0] tg, bit [31:0] v);
    byp_valid = 1; byp_tag = tg; byp_value = v;
    for (int i = 0; i < NSLOT; i++) begin
      if (slots[i].a_wait && slots[i].a_src == tg) begin
        slots[i].a_wait = 0; slots[i].a_val = v;
      end
      if (slots[i].b_wait && slots[i].b_src == tg) begin
        slots[i].b_wait = 0; slots[i].b_val = v;
      end
    end
  endfunction

  // Apply one request to the model and return the expected result
  function automatic rsalu_pkg::rsp_t station_step(rsalu_pkg::req_t r);
    rsalu_pkg::rsp_t o;
    slot_t blank;
    o = '0;
    blank = '{default: 0};
    case (r.action)
      rsalu_pkg::ACT_INSERT: begin
        o.status = 1;
        for (int i = 0; i < NSLOT; i++) begin
          if (!slots[i].busy) begin
            slots[i] = blank;
            slots[i].busy = 1; slots[i].writes = r.writes_reg;
            slots[i].a_val = r.operand_a; slots[i].b_val = r.operand_b;
            slots[i].a_wait = r.a_pending; slots[i].a_src = r.a_tag;
            slots[i].b_wait = r.b_pending; slots[i].b_src = r.b_tag;
            slots[i].op = r.opcode; slots[i].id = r.entry_tag;
            if (byp_valid && slots[i].a_wait && slots[i].a_src == byp_tag) begin
              slots[i].a_wait = 0; slots[i].a_val = byp_value;
            end
            if (byp_valid && slots[i].b_wait && slots[i].b_src == byp_tag) begin
              slots[i].b_wait = 0; slots[i].b_val = byp_value;
            end
            o.status = 0; o.slot_index = 4'(i);
            break;
          end
        end
      end
      rsalu_pkg::ACT_BROADCAST: wake_tag(r.entry_tag, r.bus_value);
      rsalu_pkg::ACT_TICK: begin
        byp_valid = 0; byp_tag = 0; byp_value = 0;
        o.status = 1;
        for (int i = 0; i < NSLOT; i++) begin
          if (slots[i].busy && !slots[i].done && !slots[i].a_wait && !slots[i].b_wait) begin
            slots[i].res = alu_calc(slots[i].op, slots[i].a_val, slots[i].b_val);
            slots[i].done = 1;
            if (slots[i].writes) wake_tag(slots[i].id, slots[i].res);
            o.status = 0; o.slot_index = 4'(i); o.result_tag = slots[i].id;
            o.result_value = slots[i].res; o.result_writes_reg = slots[i].writes;
            o.issued = 1;
            break;
          end
        end
      end
      rsalu_pkg::ACT_FIND: begin
        o.status = 1;
        for (int i = r.slot; i < NSLOT; i++) begin
          if (slots[i].busy && slots[i].done) begin
            o.status = 0; o.slot_index = 4'(i);
            o.result_tag = slots[i].id; o.result_value = slots[i].res;
            break;
          end
        end
      end
      rsalu_pkg::ACT_RELEASE: begin
        slots[r.slot] = blank;
        o.slot_index = r.slot;
      end
      rsalu_pkg::ACT_FLUSH: for (int i = 0; i < NSLOT; i++) slots[i] = blank;
      default: ;
    endcase
    return o;
  endfunction

  function automatic bit [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic rsalu_pkg::req_t rand_insert(bit pend_ok);
    rsalu_pkg::req_t r;
    r = '0;
    r.action = rsalu_pkg::ACT_INSERT;
    r.writes_reg = 1'($urandom_range(0, 1));
    r.operand_a = rand_word();
    r.operand_b = rand_word();
    r.a_pending = pend_ok && ($urandom_range(0, 3) == 0);
    r.b_pending = pend_ok && ($urandom_range(0, 3) == 0);
    r.a_tag = 5'($urandom); r.b_tag = 5'($urandom);
    r.opcode = 4'($urandom); r.entry_tag = 5'($urandom);
    r.bus_value = $urandom; r.slot = 4'($urandom);
    return r;
  endfunction

  function automatic rsalu_pkg::req_t simple_req(rsalu_pkg::action_t a, bit [3:0] s);
    rsalu_pkg::req_t r;
    r = '0;
    r.action = a; r.slot = s;
    r.entry_tag = 5'($urandom); r.bus_value = rand_word();
    return r;
  endfunction

  // Driver: requests from the pending queue, random idle
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Prediction on each accepted request
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) expected_rsps.push_back(station_step(in_data));
  end

  // Receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    rsalu_pkg::rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (e.status !== out_data.status)
          $display("%0t: status exp %h got %h", $realtime, e.status, out_data.status);
        if (e.slot_index !== out_data.slot_index)
          $display("%0t: slot_index exp %h got %h", $realtime, e.slot_index,
                   out_data.slot_index);
        if (e.result_tag !== out_data.result_tag)
          $display("%0t: result_tag exp %h got %h", $realtime, e.result_tag,
                   out_data.result_tag);
        if (e.result_value !== out_data.result_value)
          $display("%0t: result_value exp %h got %h", $realtime, e.result_value,
                   out_data.result_value);
        if (e.result_writes_reg !== out_data.result_writes_reg)
          $display("%0t: result_writes_reg exp %h got %h", $realtime,
                   e.result_writes_reg, out_data.result_writes_reg);
        if (e.issued !== out_data.issued)
          $display("%0t: issued exp %h got %h", $realtime, e.issued, out_data.issued);
        if (e !== out_data) errors++;
      end
    end
  end

  // Run-length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
  endtask

  // Well-formed burst: inserts with tags, broadcasts, ticks, finds, releases, an occasional flush
  task automatic queue_burst();
    rsalu_pkg::req_t r;
    int n;
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_insert(1));
    for (int i = 0; i < n + 2; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r = simple_req(rsalu_pkg::ACT_BROADCAST, 0);
          pending_reqs.push_back(r);
        end
        2: pending_reqs.push_back(simple_req(rsalu_pkg::ACT_FIND, 4'($urandom)));
        3: pending_reqs.push_back(rand_insert(1));
        default: pending_reqs.push_back(simple_req(rsalu_pkg::ACT_TICK, 0));
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        pending_reqs.push_back(simple_req(rsalu_pkg::ACT_FIND, 0));
      else
        pending_reqs.push_back(simple_req(rsalu_pkg::ACT_RELEASE, 4'($urandom)));
    end
    if ($urandom_range(0, 15) == 0)
      pending_reqs.push_back(simple_req(rsalu_pkg::ACT_FLUSH, 0));
  endtask

  // Queue is empty before each burst, so its size is the burst length
  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    while (count > 0) begin
      queue_burst();
      count -= pending_reqs.size();
      wait_drained();
    end
  endtask

  initial begin
    rsalu_pkg::req_t r;
    foreach (slots[i]) slots[i] = '{default: 0};
    byp_valid = 0; byp_tag = 0; byp_value = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode with edge operands, then full station
    for (int op = 0; op < 16; op++) begin
      r = rand_insert(0);
      r.opcode = 4'(op);
      r.operand_a = (op == rsalu_pkg::OP_DIV) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.operand_b = (op == rsalu_pkg::OP_DIV) ? 32'hFFFF_FFFF : 32'h0000_001F;
      pending_reqs.push_back(r);
    end
    r = rand_insert(0); r.opcode = rsalu_pkg::OP_DIV; r.operand_b = 0;
    pending_reqs.push_back(r);
    r = rand_insert(0);
    r.a_pending = 1; r.b_pending = 1; r.a_tag = 5'd31; r.b_tag = 5'd0;
    pending_reqs.push_back(r);
    pending_reqs.push_back(simple_req(rsalu_pkg::ACT_INSERT, 0)); // station full
    for (int i = 0; i < 4; i++) pending_reqs.push_back(simple_req(rsalu_pkg::ACT_TICK, 0));
    pending_reqs.push_back(simple_req(rsalu_pkg::ACT_FIND, 4'hF));
    pending_reqs.push_back(simple_req(rsalu_pkg::ACT_RELEASE, 4'hF));
    pending_reqs.push_back(simple_req(rsalu_pkg::ACT_FLUSH, 0));
    pending_reqs.push_back(simple_req(rsalu_pkg::ACT_TICK, 0));
    wait_drained();

    // Random phases with idle and stall mixes
    run_phase(0, 0, 250);
    run_phase(88, 0, 150);
    run_phase(0, 88, 150);
    run_phase(23, 23, 200);
    // Long receiver hold-off while requests keep coming
    hold_off = 300;
    run_phase(0, 0, 200);

    repeat (200) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: reservation_station_alu_unit.f
design/rsalu_pkg.sv
design/rsalu_ctrl.sv
design/rsalu_dp.sv
design/reservation_station_alu_unit.sv
verif/tb_reservation_station_alu_unit.sv
